// File: hw/rtl/bspc_pkg.sv
// Shared types and constants for the B-spline curve point evaluator.
// Depends on nothing; imported by the interfaces, the divider, the top and the checker.
`default_nettype none

package bspc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned U_W        = 16;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned BASIS_W    = 32;
  localparam int unsigned BASIS_FRAC = 30;
  localparam int unsigned DIV_DIGITS = 8;

  localparam logic [BASIS_W-1:0] BASIS_ONE = BASIS_W'(1) << BASIS_FRAC;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LRD,
    ST_LDAT,
    ST_OPS,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_SRD,
    ST_SXOPS,
    ST_SXMUL,
    ST_SYOPS,
    ST_SYMUL,
    ST_SACC,
    ST_FIN,
    ST_OUT
  } bspc_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/bspc_if.sv
// Valid/ready channel interfaces for the command input and the point output.
// Depends on bspc_pkg for the field widths.
`default_nettype none

interface bspc_in_if import bspc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [INDEX_W-1:0]        index;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic [U_W-1:0]            u;

  modport source (output valid, op, index, px, py, u, input ready);
  modport sink   (input valid, op, index, px, py, u, output ready);
endinterface

interface bspc_out_if import bspc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;

  modport source (output valid, x, y, input ready);
  modport sink   (input valid, x, y, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bspc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bspc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/bspc_div.sv
// Iterative divider by a small divisor: DIV_DIGITS quotient bits per cycle.
// Depends on bspc_pkg for DIV_DIGITS.
`default_nettype none

module bspc_div import bspc_pkg::*; #(
  parameter int unsigned NUM_W = 38,
  parameter int unsigned DEN_W = 2,
  parameter int unsigned QUO_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned STEPS = (NUM_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int unsigned PADW  = STEPS * DIV_DIGITS;
  localparam int unsigned CNTW  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [PADW-1:0] num_q, num_d;
  logic [PADW-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;

  always_comb begin
    logic [DEN_W:0]          part;
    logic [DEN_W-1:0]        rem;
    logic [DIV_DIGITS-1:0]   qd;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem    = rem_q;
    qd     = '0;
    for (int k = 0; k < DIV_DIGITS; k++) begin
      part = {rem, num_q[PADW-1-k]};
      if (part >= {1'b0, den_q}) begin
        part = part - {1'b0, den_q};
        qd[DIV_DIGITS-1-k] = 1'b1;
      end
      rem = part[DEN_W-1:0];
    end
    if (start_i) begin
      num_d  = PADW'(num_i);
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << DIV_DIGITS;
      quo_d = (quo_q << DIV_DIGITS) | PADW'(qd);
      rem_d = rem;
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q[QUO_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/bspline_curve_point_eval.sv
// Top level of the clamped uniform B-spline curve point evaluator.
// Depends on bspc_pkg, bspc_if, bspc_ram and bspc_div.
//
// A load (op 0) writes one control point and the block is ready again in the
// next cycle; an index beyond the store is dropped. An evaluate (op 1) runs
// the Cox-de Boor triangle on one shared multiplier and one iterative divider,
// then forms the weighted sum per axis on the same multiplier. The divider
// takes S = ceil(TW/8) steps per division (TW = 38 bits at the defaults, so
// S = 5). A parameter at or past the end of the curve returns the last
// control point. The input is not ready until the result is in the output
// register. Points read as zero until written, tracked by one valid flop per
// entry.
`default_nettype none

module bspline_curve_point_eval import bspc_pkg::*; #(
  parameter int unsigned NUM_POINTS = 12,
  parameter int unsigned DEGREE     = 3,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bspc_in_if.sink    in_i,
  bspc_out_if.source out_o
);

  localparam int unsigned KNOT_MAX = NUM_POINTS - DEGREE;
  localparam int unsigned AW       = $clog2(NUM_POINTS);
  localparam int unsigned SW       = $clog2(KNOT_MAX + 1);
  localparam int unsigned KVW      = SW + 4;
  localparam int unsigned CW       = $clog2(DEGREE + 1);
  localparam int unsigned LRW      = FRAC_BITS + CW;
  localparam int unsigned XW0      = ((SW + FRAC_BITS) > U_W) ? SW + FRAC_BITS : U_W;
  localparam int unsigned XW       = (XW0 > LRW) ? XW0 : LRW;
  localparam int unsigned OBW      = ((LRW > COORD_W) ? LRW : COORD_W) + 1;
  localparam int unsigned PW       = BASIS_W + 1 + OBW;
  localparam int unsigned TW       = PW - FRAC_BITS;
  localparam int unsigned ACCW     = COORD_W + BASIS_W + CW + 1;
  localparam int unsigned RW       = ACCW - BASIS_FRAC;
  localparam logic [31:0] END_U    = 32'(KNOT_MAX) << FRAC_BITS;
  localparam logic signed [RW-1:0] Q_MAX = RW'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [RW-1:0] Q_MIN = ~Q_MAX;

  function automatic logic [SW-1:0] knot_at(input logic signed [KVW-1:0] v);
    logic [SW-1:0] k;
    if (v < 0) begin
      k = '0;
    end else if (v > $signed(KVW'(KNOT_MAX))) begin
      k = SW'(KNOT_MAX);
    end else begin
      k = v[SW-1:0];
    end
    return k;
  endfunction

  function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [ACCW-1:0] acc);
    logic signed [ACCW-1:0]    rs;
    logic signed [RW-1:0]      q;
    logic signed [COORD_W-1:0] res;
    rs = acc + $signed(ACCW'(1) << (BASIS_FRAC - 1));
    q  = rs[ACCW-1:BASIS_FRAC];
    if (q > Q_MAX) begin
      res = Q_MAX[COORD_W-1:0];
    end else if (q < Q_MIN) begin
      res = Q_MIN[COORD_W-1:0];
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

  bspc_state_e state_q, state_d;

  logic [CW-1:0]  j_q, j_d;
  logic [CW-1:0]  r_q, r_d;
  logic           side_q, side_d;
  logic [CW-1:0]  bidx;
  logic [NUM_POINTS-1:0] pv_q, pv_d;

  logic [U_W-1:0]     u_q, u_d;
  logic [SW-1:0]      s_q, s_d;
  logic [BASIS_W-1:0] basis_q [DEGREE+1];
  logic [BASIS_W-1:0] basis_d [DEGREE+1];
  logic [BASIS_W-1:0] saved_q, saved_d;
  logic [BASIS_W-1:0] a_q, a_d;
  logic signed [BASIS_W:0]    op_a_q, op_a_d;
  logic signed [OBW-1:0]      op_b_q, op_b_d;
  logic signed [PW-1:0]       prod_q, prod_d;
  logic signed [COORD_W-1:0]  cy_q, cy_d;
  logic signed [ACCW-1:0]     accx_q, accx_d;
  logic signed [ACCW-1:0]     accy_q, accy_d;
  logic signed [COORD_W-1:0]  res_x_q, res_x_d;
  logic signed [COORD_W-1:0]  res_y_q, res_y_d;
  logic                       vld_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0]  out_x_q, out_x_d;
  logic signed [COORD_W-1:0]  out_y_q, out_y_d;

  logic                  in_fire;
  logic                  idx_ok;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [2*COORD_W-1:0]  ram_rdata;
  logic signed [COORD_W-1:0] cx_rd;
  logic signed [COORD_W-1:0] cy_rd;

  logic signed [KVW-1:0] kv_r;
  logic signed [KVW-1:0] kv_l;
  logic [SW-1:0]         kr;
  logic [SW-1:0]         kl;
  logic [SW-1:0]         dk;
  logic [XW-1:0]         diff_r;
  logic [XW-1:0]         diff_l;
  logic [LRW-1:0]        right_v;
  logic [LRW-1:0]        left_v;
  logic [CW-1:0]         den;
  logic [PW-1:0]         tsum;
  logic [TW-1:0]         div_num;
  logic                  div_start;
  logic                  div_done;
  logic [BASIS_W-1:0]    div_quo;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign idx_ok     = 32'(in_i.index) < NUM_POINTS;
  assign ram_we     = in_fire && (in_i.op == OP_LOAD) && idx_ok;
  assign ram_waddr  = AW'(in_i.index);
  assign ram_raddr  = (state_q == ST_LRD) ? AW'(NUM_POINTS - 1) : AW'(s_q) + AW'(j_q);

  bspc_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (NUM_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_i.px, in_i.py}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cx_rd = vld_q ? $signed(ram_rdata[2*COORD_W-1:COORD_W]) : '0;
  assign cy_rd = vld_q ? $signed(ram_rdata[COORD_W-1:0]) : '0;

  assign kv_r    = KVW'(s_q) + KVW'(r_q) + KVW'(1);
  assign kv_l    = KVW'(s_q) + KVW'(r_q) + KVW'(1) - KVW'(j_q);
  assign kr      = knot_at(kv_r);
  assign kl      = knot_at(kv_l);
  assign dk      = kr - kl;
  assign den     = CW'(dk);
  assign diff_r  = (XW'(kr) << FRAC_BITS) - XW'(u_q);
  assign diff_l  = XW'(u_q) - (XW'(kl) << FRAC_BITS);
  assign right_v = diff_r[LRW-1:0];
  assign left_v  = diff_l[LRW-1:0];

  assign prod_d  = op_a_q * op_b_q;
  assign tsum    = $unsigned(prod_q) + (PW'(den) << (FRAC_BITS - 1));
  assign div_num = tsum[PW-1:FRAC_BITS];

  bspc_div #(
    .NUM_W (TW),
    .DEN_W (CW),
    .QUO_W (BASIS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    r_d         = r_q;
    side_d      = side_q;
    pv_d        = pv_q;
    u_d         = u_q;
    s_d         = s_q;
    basis_d     = basis_q;
    saved_d     = saved_q;
    a_d         = a_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    cy_d        = cy_q;
    accx_d      = accx_q;
    accy_d      = accy_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    div_start   = 1'b0;
    ram_re      = 1'b0;
    bidx        = r_q;

    if (ram_we) begin
      pv_d[ram_waddr] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.op == OP_EVAL)) begin
          u_d        = in_i.u;
          s_d        = SW'(in_i.u >> FRAC_BITS);
          j_d        = CW'(1);
          r_d        = '0;
          side_d     = 1'b0;
          saved_d    = '0;
          basis_d[0] = BASIS_ONE;
          accx_d     = '0;
          accy_d     = '0;
          if (32'(in_i.u) >= END_U) begin
            state_d = ST_LRD;
          end else begin
            state_d = ST_OPS;
          end
        end
      end
      ST_LRD: begin
        ram_re  = 1'b1;
        state_d = ST_LDAT;
      end
      ST_LDAT: begin
        res_x_d = cx_rd;
        res_y_d = cy_rd;
        state_d = ST_OUT;
      end
      ST_OPS: begin
        op_a_d  = $signed({1'b0, basis_q[bidx]});
        op_b_d  = side_q ? $signed(OBW'(left_v)) : $signed(OBW'(right_v));
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          if (!side_q) begin
            a_d     = div_quo;
            side_d  = 1'b1;
            state_d = ST_OPS;
          end else begin
            side_d       = 1'b0;
            basis_d[r_q] = saved_q + a_q;
            if (r_q == j_q - CW'(1)) begin
              basis_d[j_q] = div_quo;
              saved_d      = '0;
              r_d          = '0;
              if (j_q == CW'(DEGREE)) begin
                j_d     = '0;
                state_d = ST_SRD;
              end else begin
                j_d     = j_q + CW'(1);
                state_d = ST_OPS;
              end
            end else begin
              saved_d = div_quo;
              r_d     = r_q + CW'(1);
              state_d = ST_OPS;
            end
          end
        end
      end
      ST_SRD: begin
        ram_re  = 1'b1;
        state_d = ST_SXOPS;
      end
      ST_SXOPS: begin
        bidx    = j_q;
        op_a_d  = $signed({1'b0, basis_q[bidx]});
        op_b_d  = $signed(OBW'(cx_rd));
        cy_d    = cy_rd;
        state_d = ST_SXMUL;
      end
      ST_SXMUL: begin
        state_d = ST_SYOPS;
      end
      ST_SYOPS: begin
        accx_d  = accx_q + $signed(ACCW'(prod_q));
        op_b_d  = $signed(OBW'(cy_q));
        state_d = ST_SYMUL;
      end
      ST_SYMUL: begin
        state_d = ST_SACC;
      end
      ST_SACC: begin
        accy_d = accy_q + $signed(ACCW'(prod_q));
        if (j_q == CW'(DEGREE)) begin
          state_d = ST_FIN;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = ST_SRD;
        end
      end
      ST_FIN: begin
        res_x_d = to_coord(accx_q);
        res_y_d = to_coord(accy_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_x_d     = res_x_q;
          out_y_d     = res_y_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      r_q         <= '0;
      side_q      <= 1'b0;
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      r_q         <= r_d;
      side_q      <= side_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q     <= u_d;
    s_q     <= s_d;
    basis_q <= basis_d;
    saved_q <= saved_d;
    a_q     <= a_d;
    op_a_q  <= op_a_d;
    op_b_q  <= op_b_d;
    prod_q  <= prod_d;
    cy_q    <= cy_d;
    accx_q  <= accx_d;
    accy_q  <= accy_d;
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
    if (ram_re) begin
      vld_q <= pv_q[ram_raddr];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.x     = out_x_q;
  assign out_o.y     = out_y_q;

endmodule

`default_nettype wire

// File: hw/rtl/bspc_checker.sv
// Port-level assertions for the B-spline curve point evaluator, bound to the top.
// Depends on bspc_pkg for the opcodes and the coordinate width.
`default_nettype none

module bspc_checker import bspc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_op_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COORD_W-1:0] out_x_i,
  input logic [COORD_W-1:0] out_y_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i))
    else $error("stalled result changed or dropped");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_EVAL) |=> !in_ready_i)
    else $error("input ready right after an evaluate transfer");

  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_LOAD) |=> in_ready_i)
    else $error("load did not complete in one cycle");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an evaluate in progress");

endmodule

bind bspline_curve_point_eval bspc_checker u_bspc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.x),
  .out_y_i     (out_o.y)
);

`default_nettype wire

// File: tb/bspline_curve_point_eval_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the cubic B-spline curve point evaluator.
// Predicts each curve point in a scoreboard class and drives both channels
// with random gaps. Depends on bspc_pkg, bspc_if and the block's RTL.

class curve_scoreboard;
  localparam int NUM_POINTS = 12;
  localparam int DEGREE     = 3;
  localparam int FRAC_BITS  = 12;
  localparam int KNOT_MAX   = NUM_POINTS - DEGREE;
  localparam int END_U      = KNOT_MAX << FRAC_BITS;

  typedef struct packed {
    logic signed [bspc_pkg::COORD_W-1:0] x;
    logic signed [bspc_pkg::COORD_W-1:0] y;
  } point_t;

  logic signed [bspc_pkg::COORD_W-1:0] ctrl_x[NUM_POINTS];
  logic signed [bspc_pkg::COORD_W-1:0] ctrl_y[NUM_POINTS];
  point_t expected_points[$];
  int errors;

  function new();
    foreach (ctrl_x[i]) begin
      ctrl_x[i] = '0;
      ctrl_y[i] = '0;
    end
    errors = 0;
  endfunction

  function int knot_at(int j);
    int k;
    k = j - DEGREE;
    if (k < 0) k = 0;
    if (k > KNOT_MAX) k = KNOT_MAX;
    return k;
  endfunction

  function logic signed [bspc_pkg::COORD_W-1:0] to_coord(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< (bspc_pkg::BASIS_FRAC - 1))) >>> bspc_pkg::BASIS_FRAC;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[bspc_pkg::COORD_W-1:0];
  endfunction

  function point_t curve_point_at(logic [bspc_pkg::U_W-1:0] u);
    longint unsigned basis[DEGREE+1];
    longint unsigned left[DEGREE+1];
    longint unsigned right[DEGREE+1];
    longint unsigned saved, den, a, b;
    longint acc_x, acc_y;
    int span;
    point_t pt;
    if (u >= END_U) begin
      pt.x = ctrl_x[NUM_POINTS-1];
      pt.y = ctrl_y[NUM_POINTS-1];
      return pt;
    end
    span = DEGREE + int'(u >> FRAC_BITS);
    basis[0] = 64'd1 << bspc_pkg::BASIS_FRAC;
    left[0] = 0;
    right[0] = 0;
    for (int j = 1; j <= DEGREE; j++) begin
      saved = 0;
      left[j] = 64'(u) - (64'(knot_at(span + 1 - j)) << FRAC_BITS);
      right[j] = (64'(knot_at(span + j)) << FRAC_BITS) - 64'(u);
      for (int r = 0; r < j; r++) begin
        den = 64'(knot_at(span + r + 1) - knot_at(span + 1 - j + r)) << FRAC_BITS;
        a = (basis[r] * right[r+1] + den / 2) / den;
        b = (basis[r] * left[j-r] + den / 2) / den;
        basis[r] = saved + a;
        saved = b;
      end
      basis[j] = saved;
    end
    acc_x = 0;
    acc_y = 0;
    for (int j = 0; j <= DEGREE; j++) begin
      acc_x += longint'(ctrl_x[span-DEGREE+j]) * longint'(basis[j]);
      acc_y += longint'(ctrl_y[span-DEGREE+j]) * longint'(basis[j]);
    end
    pt.x = to_coord(acc_x);
    pt.y = to_coord(acc_y);
    return pt;
  endfunction

  function void note_command(logic op, logic [bspc_pkg::INDEX_W-1:0] index,
                             logic signed [bspc_pkg::COORD_W-1:0] px,
                             logic signed [bspc_pkg::COORD_W-1:0] py,
                             logic [bspc_pkg::U_W-1:0] u);
    if (op == bspc_pkg::OP_LOAD) begin
      if (index < NUM_POINTS) begin
        ctrl_x[index] = px;
        ctrl_y[index] = py;
      end
    end else begin
      expected_points.push_back(curve_point_at(u));
    end
  endfunction

  function void check_point(logic signed [bspc_pkg::COORD_W-1:0] x,
                            logic signed [bspc_pkg::COORD_W-1:0] y);
    point_t want;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected point x=%0d y=%0d", $time, x, y);
      errors++;
      return;
    end
    want = expected_points.pop_front();
    if (want.x !== x)
      $display("%0t: x mismatch: expected %0d, actual %0d", $time, want.x, x);
    if (want.y !== y)
      $display("%0t: y mismatch: expected %0d, actual %0d", $time, want.y, y);
    if (want.x !== x || want.y !== y) errors++;
  endfunction
endclass

module bspline_curve_point_eval_tb import bspc_pkg::*; ();

  localparam int RANDOM_ITEMS   = 1450;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam int TAIL_CYCLES    = 150;
  localparam int NUM_POINTS     = 12;
  localparam int DEGREE         = 3;
  localparam int FRAC_BITS      = 12;
  localparam int END_U          = (NUM_POINTS - DEGREE) << FRAC_BITS;

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   idle_cycles;
  int   sent_items;

  curve_scoreboard scoreboard;

  bspc_in_if  cmd_if ();
  bspc_out_if pt_if ();

  bspline_curve_point_eval u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (pt_if)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [U_W-1:0] rand_u();
    int r;
    r = $urandom_range(99);
    if (r < 75) return U_W'($urandom_range(0, END_U - 1));
    if (r < 88) return U_W'($urandom_range(0, 9) * 4096 + $urandom_range(0, 2) - 1);
    return U_W'($urandom_range(END_U, 65535));
  endfunction

  task automatic send_cmd(input logic op, input logic [INDEX_W-1:0] index,
                          input logic signed [COORD_W-1:0] px,
                          input logic signed [COORD_W-1:0] py,
                          input logic [U_W-1:0] u);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.op    <= op;
    cmd_if.index <= index;
    cmd_if.px    <= px;
    cmd_if.py    <= py;
    cmd_if.u     <= u;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    scoreboard.note_command(op, index, px, py, u);
  endtask

  task automatic load_point(input logic [INDEX_W-1:0] index,
                            input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    send_cmd(OP_LOAD, index, px, py, U_W'($urandom));
  endtask

  task automatic eval_at(input logic [U_W-1:0] u);
    send_cmd(OP_EVAL, INDEX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), u);
  endtask

  initial begin
    int stall;
    pt_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pt_if.ready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        @(negedge clk_i);
        pt_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pt_if.valid && pt_if.ready)
      scoreboard.check_point(pt_if.x, pt_if.y);
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (pt_if.valid && pt_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bspline_curve_point_eval_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [INDEX_W-1:0]        index;
    scoreboard   = new();
    steady       = 1'b0;
    idle_cycles  = 0;
    sent_items   = 0;
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.op    = OP_LOAD;
    cmd_if.index = '0;
    cmd_if.px    = '0;
    cmd_if.py    = '0;
    cmd_if.u     = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    eval_at(16'd0);
    eval_at(16'hFFFF);
    load_point(4'd0, 16'sh7FFF, 16'sh8000);
    load_point(4'd11, 16'sh8000, 16'sh7FFF);
    load_point(4'd5, -16'sd1, 16'sd1);
    load_point(4'd12, 16'sh1234, 16'sh4321);
    load_point(4'd15, 16'sh7FFF, 16'sh7FFF);
    eval_at(16'd0);
    eval_at(16'(END_U - 1));
    eval_at(16'(END_U));
    eval_at(16'hFFFF);
    eval_at(16'd4096);
    eval_at(16'd22528);
    eval_at(16'd32768);
    for (int i = 4; i <= 7; i++) load_point(INDEX_W'(i), 16'sh7FFF, 16'sh8000);
    eval_at(16'd18432);
    eval_at(16'd20480);
    eval_at(16'd1);

    while (sent_items < RANDOM_ITEMS) begin
      if ($urandom_range(59) == 0) steady = !steady;
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(9) == 0) index = INDEX_W'($urandom_range(12, 15));
        else index = INDEX_W'($urandom_range(0, 11));
        load_point(index, rand_coord(), rand_coord());
        if (index < NUM_POINTS) sent_items++;
      end else begin
        eval_at(rand_u());
        sent_items++;
      end
    end
    steady = 1'b0;

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (scoreboard.expected_points.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (scoreboard.errors == 0) begin
      $display("bspline_curve_point_eval_tb: clean");
    end else begin
      $display("bspline_curve_point_eval_tb: errors");
    end
    $finish;
  end

endmodule
